@@ hw/rtl/toes_pkg.sv @@
// ----------------------------------------------------------------------------
// toes_pkg
// Shared types and codes for the timed overlay entry scheduler.
// ----------------------------------------------------------------------------
package toes_pkg;

  localparam int FLAG_BITS = 3;
  localparam int F_VALID   = 0;
  localparam int F_ACTIVE  = 1;
  localparam int F_CLEAR   = 2;

  localparam int SPRITE_BITS = 16;
  localparam int KIND_BITS   = 3;
  localparam int DUR_BITS    = 32;
  localparam int TICK_BITS   = 20;
  localparam int DDUR_BITS   = 27;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic [2:0] KIND_REMOVE  = 3'd0;
  localparam logic [2:0] KIND_SHOW    = 3'd1;
  localparam logic [2:0] KIND_STORED  = 3'd2;
  localparam logic [2:0] KIND_FULL    = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;
  localparam logic [2:0] KIND_TIMESET = 3'd5;
  localparam logic [2:0] KIND_FLUSH   = 3'd6;

  localparam logic [1:0] REG_TICK_INTERVAL = 2'd0;
  localparam logic [1:0] REG_DEFAULT_DUR   = 2'd1;

  localparam logic [1:0] CELL_HOLD     = 2'd0;
  localparam logic [1:0] CELL_ROTATE   = 2'd1;
  localparam logic [1:0] CELL_COLLAPSE = 2'd2;
  localparam logic [1:0] CELL_INSERT   = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [FLAG_BITS-1:0]   new_flags;
    logic [SPRITE_BITS-1:0] new_sprite;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/toes_cell.sv @@
// ----------------------------------------------------------------------------
// toes_cell
// One table entry; rotates toward the head, collapses over killed entries,
// or takes a new entry when it is the first free slot.
// ----------------------------------------------------------------------------
module toes_cell #(
  parameter int TIME_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  toes_pkg::cell_ctrl_t             ctrl,
  input  logic                             hole_in,
  input  logic                             left_valid,
  input  logic [TIME_BITS-1:0]             new_start,
  input  logic [TIME_BITS-1:0]             new_stop,
  input  logic [TIME_BITS-1:0]             r_start,
  input  logic [TIME_BITS-1:0]             r_stop,
  input  logic [toes_pkg::SPRITE_BITS-1:0] r_sprite,
  input  logic [toes_pkg::FLAG_BITS-1:0]   r_flags,
  input  logic                             r_kill,
  output logic [TIME_BITS-1:0]             start,
  output logic [TIME_BITS-1:0]             stop,
  output logic [toes_pkg::SPRITE_BITS-1:0] sprite,
  output logic [toes_pkg::FLAG_BITS-1:0]   flags,
  output logic                             kill,
  output logic                             hole_out
);

  logic take_right;
  logic take_new;

  assign hole_out   = hole_in | kill;
  assign take_right = (ctrl.op == toes_pkg::CELL_ROTATE) ||
                      ((ctrl.op == toes_pkg::CELL_COLLAPSE) && hole_out);
  assign take_new   = (ctrl.op == toes_pkg::CELL_INSERT) &&
                      !flags[toes_pkg::F_VALID] && left_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      kill  <= 1'b0;
    end else if (take_right) begin
      flags <= r_flags;
      kill  <= r_kill;
    end else if (take_new) begin
      flags <= ctrl.new_flags;
      kill  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_right) begin
      start  <= r_start;
      stop   <= r_stop;
      sprite <= r_sprite;
    end else if (take_new) begin
      start  <= new_start;
      stop   <= new_stop;
      sprite <= ctrl.new_sprite;
    end
  end

endmodule

@@ hw/rtl/timed_overlay_entry_scheduler_top.sv @@
// Throughput: one item at a time; a tick walks the cell ring three or four
// times, one cell a cycle while the output is not stalled (the collapse walk
// does not wait), and each step of the other walks can post one result beat.
// Reset (rst, synchronous): table empty, current time zero, registers at
// defaults, no beat pending.
// ----------------------------------------------------------------------------
// timed_overlay_entry_scheduler_top
// Timed overlay entry table as a ring of cells with a walking controller.
// ----------------------------------------------------------------------------
module timed_overlay_entry_scheduler_top #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [toes_pkg::DDUR_BITS-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [TIME_BITS-1:0]             time_value,
  input  logic [toes_pkg::DUR_BITS-1:0]    duration,
  input  logic [toes_pkg::SPRITE_BITS-1:0] sprite_id,
  input  logic                             clear_marker,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [toes_pkg::KIND_BITS-1:0]   kind,
  output logic [toes_pkg::SPRITE_BITS-1:0] sprite_id_res,
  output logic                             last
);

  localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_W1    = 3'd2;
  localparam logic [2:0] S_W2    = 3'd3;
  localparam logic [2:0] S_COL   = 3'd4;
  localparam logic [2:0] S_W3    = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]                       state, state_next;
  logic [CW-1:0]                    cnt, cnt_next;
  logic                             clear_hit, clear_hit_next;
  logic [2:0]                       fin_kind, fin_kind_next;
  logic [toes_pkg::TICK_BITS-1:0]   tick_interval;
  logic [toes_pkg::DDUR_BITS-1:0]   default_duration;
  logic [TIME_BITS-1:0]             current_time, current_time_next;
  logic [TIME_BITS-1:0]             tv;
  logic [toes_pkg::DUR_BITS-1:0]    dur;
  logic [toes_pkg::SPRITE_BITS-1:0] spr;
  logic                             marker;

  logic [TIME_BITS-1:0]             c_start  [ENTRIES+1];
  logic [TIME_BITS-1:0]             c_stop   [ENTRIES+1];
  logic [toes_pkg::SPRITE_BITS-1:0] c_sprite [ENTRIES+1];
  logic [toes_pkg::FLAG_BITS-1:0]   c_flags  [ENTRIES+1];
  logic                             c_kill   [ENTRIES+1];
  logic                             hole     [ENTRIES+1];
  logic                             lvalid   [ENTRIES+1];
  logic [ENTRIES-1:0]               valid_vec;
  logic [ENTRIES-1:0]               kill_vec;
  logic [toes_pkg::FLAG_BITS-1:0]   t_flags;
  logic                             t_kill;

  toes_pkg::cell_ctrl_t             ctrl;
  logic [TIME_BITS-1:0]             new_stop;
  logic [TIME_BITS:0]               stop_sum;
  logic [TIME_BITS:0]               time_sum;
  logic [toes_pkg::DUR_BITS-1:0]    dur_sel;

  logic                             can_step;
  logic                             emit;
  logic [2:0]                       emit_kind;
  logic [toes_pkg::SPRITE_BITS-1:0] emit_spr;
  logic                             emit_last;

  logic                             h_valid, h_active, h_clear, h_shown;
  logic                             h_due_stop, h_due_start;
  logic                             full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign can_step  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval    <= toes_pkg::TICK_BITS'(16667);
      default_duration <= toes_pkg::DDUR_BITS'(2000000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        toes_pkg::REG_TICK_INTERVAL: tick_interval    <= cfg_data[toes_pkg::TICK_BITS-1:0];
        toes_pkg::REG_DEFAULT_DUR:   default_duration <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tv     <= time_value;
      dur    <= duration;
      spr    <= sprite_id;
      marker <= clear_marker;
    end
  end

  // ring: cell i takes from i+1, the tail from the head, with flags and kill from the controller
  assign hole[0]   = 1'b0;
  assign lvalid[0] = 1'b1;

  assign c_start[ENTRIES]  = c_start[0];
  assign c_stop[ENTRIES]   = c_stop[0];
  assign c_sprite[ENTRIES] = c_sprite[0];
  assign c_flags[ENTRIES]  = t_flags;
  assign c_kill[ENTRIES]   = t_kill;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    toes_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .hole_in    (hole[g]),
      .left_valid (lvalid[g]),
      .new_start  (tv),
      .new_stop   (new_stop),
      .r_start    (c_start[g+1]),
      .r_stop     (c_stop[g+1]),
      .r_sprite   (c_sprite[g+1]),
      .r_flags    (c_flags[g+1]),
      .r_kill     (c_kill[g+1]),
      .start      (c_start[g]),
      .stop       (c_stop[g]),
      .sprite     (c_sprite[g]),
      .flags      (c_flags[g]),
      .kill       (c_kill[g]),
      .hole_out   (hole[g+1])
    );
    assign lvalid[g+1]  = c_flags[g][toes_pkg::F_VALID];
    assign valid_vec[g] = c_flags[g][toes_pkg::F_VALID];
    assign kill_vec[g]  = c_kill[g];
  end

  assign full        = c_flags[ENTRIES-1][toes_pkg::F_VALID];
  assign h_valid     = c_flags[0][toes_pkg::F_VALID];
  assign h_active    = c_flags[0][toes_pkg::F_ACTIVE];
  assign h_clear     = c_flags[0][toes_pkg::F_CLEAR];
  assign h_shown     = h_valid && h_active && !h_clear;
  assign h_due_stop  = h_valid && (current_time >= c_stop[0]);
  assign h_due_start = h_valid && !h_active && (current_time >= c_start[0]);

  assign dur_sel  = (dur != '0) ? dur : toes_pkg::DUR_BITS'(default_duration);
  assign stop_sum = {1'b0, tv} + (TIME_BITS+1)'(dur_sel);
  assign new_stop = marker ? tv :
                    (stop_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : stop_sum[TIME_BITS-1:0]);
  assign time_sum = {1'b0, current_time} + (TIME_BITS+1)'(tick_interval);

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    clear_hit_next    = clear_hit;
    fin_kind_next     = fin_kind;
    current_time_next = current_time;
    ctrl.op           = toes_pkg::CELL_HOLD;
    ctrl.new_flags    = marker ? toes_pkg::FLAG_BITS'((1 << toes_pkg::F_VALID) |
                                                      (1 << toes_pkg::F_CLEAR))
                               : toes_pkg::FLAG_BITS'(1 << toes_pkg::F_VALID);
    ctrl.new_sprite   = marker ? '0 : spr;
    t_flags           = c_flags[0];
    t_kill            = c_kill[0];
    emit              = 1'b0;
    emit_kind         = toes_pkg::KIND_REMOVE;
    emit_spr          = c_sprite[0];
    emit_last         = 1'b0;

    unique case (state)
      S_IDLE: begin
        cnt_next       = '0;
        clear_hit_next = 1'b0;
        if (in_valid) begin
          unique case (cmd)
            toes_pkg::CMD_ADD:   state_next = S_ADD;
            toes_pkg::CMD_TICK:  state_next = S_W1;
            toes_pkg::CMD_SET: begin
              state_next    = S_FIN;
              fin_kind_next = toes_pkg::KIND_TIMESET;
            end
            toes_pkg::CMD_FLUSH: state_next = S_FLUSH;
            default: ;
          endcase
        end
      end
      S_ADD: begin
        if (can_step) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_spr   = '0;
          emit_kind  = full ? toes_pkg::KIND_FULL : toes_pkg::KIND_STORED;
          ctrl.op    = full ? toes_pkg::CELL_HOLD : toes_pkg::CELL_INSERT;
          state_next = S_IDLE;
        end
      end
      S_W1: begin
        t_kill = h_due_stop;
        if (can_step) begin
          ctrl.op  = toes_pkg::CELL_ROTATE;
          emit     = h_due_stop && h_shown;
          cnt_next = cnt + CW'(1);
          if (h_due_stop && h_clear) clear_hit_next = 1'b1;
          if (cnt == LAST_IDX) begin
            cnt_next   = '0;
            state_next = (clear_hit || (h_due_stop && h_clear)) ? S_W2 : S_COL;
          end
        end
      end
      S_W2: begin
        if (!c_kill[0] && h_valid && h_active) t_kill = 1'b1;
        if (can_step) begin
          ctrl.op  = toes_pkg::CELL_ROTATE;
          emit     = !c_kill[0] && h_shown;
          cnt_next = cnt + CW'(1);
          if (cnt == LAST_IDX) begin
            cnt_next   = '0;
            state_next = S_COL;
          end
        end
      end
      S_COL: begin
        ctrl.op  = toes_pkg::CELL_COLLAPSE;
        t_flags  = '0;
        t_kill   = 1'b0;
        cnt_next = cnt + CW'(1);
        if (cnt == LAST_IDX) begin
          cnt_next   = '0;
          state_next = S_W3;
        end
      end
      S_W3: begin
        if (h_due_start) t_flags[toes_pkg::F_ACTIVE] = 1'b1;
        emit_kind = toes_pkg::KIND_SHOW;
        if (can_step) begin
          ctrl.op  = toes_pkg::CELL_ROTATE;
          emit     = h_due_start && !h_clear;
          cnt_next = cnt + CW'(1);
          if (cnt == LAST_IDX) begin
            cnt_next      = '0;
            state_next    = S_FIN;
            fin_kind_next = toes_pkg::KIND_TICK;
          end
        end
      end
      S_FLUSH: begin
        t_flags = '0;
        t_kill  = 1'b0;
        if (can_step) begin
          ctrl.op  = toes_pkg::CELL_ROTATE;
          emit     = h_shown;
          cnt_next = cnt + CW'(1);
          if (cnt == LAST_IDX) begin
            cnt_next      = '0;
            state_next    = S_FIN;
            fin_kind_next = toes_pkg::KIND_FLUSH;
          end
        end
      end
      S_FIN: begin
        if (can_step) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          emit_spr   = '0;
          emit_kind  = fin_kind;
          state_next = S_IDLE;
          if (fin_kind == toes_pkg::KIND_TIMESET) begin
            current_time_next = tv;
          end else if (fin_kind == toes_pkg::KIND_TICK) begin
            current_time_next = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}}
                                                    : time_sum[TIME_BITS-1:0];
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      clear_hit    <= 1'b0;
      fin_kind     <= toes_pkg::KIND_TICK;
      current_time <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      clear_hit    <= clear_hit_next;
      fin_kind     <= fin_kind_next;
      current_time <= current_time_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind          <= emit_kind;
      sprite_id_res <= emit_spr;
      last          <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_no_kill_after_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_COL && cnt == LAST_IDX) |=> (kill_vec == '0))
    else $error("killed entries left after collapse");

  a_compact_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (((valid_vec + ENTRIES'(1)) & valid_vec) == '0))
    else $error("table not compacted while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted beat did not start work");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result beat overwrote pending beat");
`endif

endmodule
